/* sv/scpc_pkg.sv */
// Shared types, constants and the arctangent table of the lidar point converter.
// No dependencies; every other file of the block uses this package.
package scpc_pkg;

	localparam int RANGE_BITS_DEF    = 16;
	localparam int ANGLE_BITS_DEF    = 16;
	localparam int CORDIC_ROUNDS_DEF = 16;

	localparam int FIELD_W   = 16;  // config and range field width
	localparam int POINT_W   = 17;  // signed point coordinate width
	localparam int CFG_IDX_W = 4;
	localparam int CW        = 34;  // CORDIC x/y datapath, 2^-30 scaled
	localparam int ZW        = 34;  // residual angle, 2^32 per turn
	localparam int FRAC      = 30;

	localparam logic [CW-1:0]      CORDIC_K             = CW'(652032874);
	localparam logic [FIELD_W-1:0] SENSOR_RANGE_MAX_RST = 16'hFFFF;
	localparam logic [FIELD_W-1:0] GATE_MAX_RST         = 16'd2500;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SENSOR_RANGE_MIN = 4'd0,
		REG_SENSOR_RANGE_MAX = 4'd1,
		REG_ANGLE_START      = 4'd2,
		REG_ANGLE_STEP       = 4'd3,
		REG_MOUNT_OFFSET_X   = 4'd4,
		REG_MOUNT_OFFSET_Y   = 4'd5,
		REG_GATE_MIN         = 4'd6,
		REG_GATE_MAX         = 4'd7
	} cfg_reg_t;

	// data handed from one rotation cell to the next
	typedef struct packed {
		logic          vld;
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic [ZW-1:0] z;
	} cell_data_t;

	// end of chain into the scaling / gate pipeline
	typedef struct packed {
		logic          vld;
		logic          flip;
		logic          win_ok;
		logic [CW-1:0] x;
		logic [CW-1:0] y;
	} post_in_t;

	typedef struct packed {
		logic               vld;
		logic               kept;
		logic [POINT_W-1:0] x;
		logic [POINT_W-1:0] y;
	} point_t;

	// atan(2^-i) in 2^32-per-turn units
	function automatic logic [31:0] atan_turn(input int unsigned idx);
		logic [31:0] a;
		case (idx)
			0:  a = 32'h20000000;
			1:  a = 32'h12E4051E;
			2:  a = 32'h09FB385B;
			3:  a = 32'h051111D4;
			4:  a = 32'h028B0D43;
			5:  a = 32'h0145D7E1;
			6:  a = 32'h00A2F61E;
			7:  a = 32'h00517C55;
			8:  a = 32'h0028BE53;
			9:  a = 32'h00145F2F;
			10: a = 32'h000A2F98;
			11: a = 32'h000517CC;
			12: a = 32'h00028BE6;
			13: a = 32'h000145F3;
			14: a = 32'h0000A2FA;
			15: a = 32'h0000517D;
			16: a = 32'h000028BE;
			17: a = 32'h0000145F;
			18: a = 32'h00000A30;
			19: a = 32'h00000518;
			20: a = 32'h0000028C;
			21: a = 32'h00000146;
			22: a = 32'h000000A3;
			23: a = 32'h00000051;
			default: a = 32'h0;
		endcase
		return a;
	endfunction

endpackage

/* sv/scpc_ifs.sv */
// Valid/ready channel interfaces: sample input, point output, config writes.
// Depends on scpc_pkg for field widths.
interface scpc_sample_if;
	logic                          valid;
	logic                          ready;
	logic [scpc_pkg::FIELD_W-1:0]  range_sample;
	logic                          sample_invalid;
	logic                          scan_start;
	modport source (output valid, range_sample, sample_invalid, scan_start, input ready);
	modport sink   (input valid, range_sample, sample_invalid, scan_start, output ready);
endinterface

interface scpc_point_if;
	logic                                valid;
	logic                                ready;
	logic signed [scpc_pkg::POINT_W-1:0] point_x;
	logic signed [scpc_pkg::POINT_W-1:0] point_y;
	logic                                point_kept;
	modport source (output valid, point_x, point_y, point_kept, input ready);
	modport sink   (input valid, point_x, point_y, point_kept, output ready);
endinterface

interface scpc_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [scpc_pkg::CFG_IDX_W-1:0] index;
	logic [scpc_pkg::FIELD_W-1:0]   data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

/* sv/scan_polar_to_cartesian_gate_unit.sv */
// Lidar sample to laser-frame point with sensor window and obstacle gate.
// Each sample runs through the rotation cell chain and four scaling/gate stages
// into the output register; one sample in flight, the next is accepted once the
// finished point has moved into the output register.
// Reset (arst_n low, async): config to defaults, beam angle 0, pipeline empty.
// Depends on scpc_pkg, scpc_ifs, scpc_cell, scpc_post.
module scan_polar_to_cartesian_gate_unit #(
	parameter int RANGE_BITS    = scpc_pkg::RANGE_BITS_DEF,
	parameter int ANGLE_BITS    = scpc_pkg::ANGLE_BITS_DEF,
	parameter int CORDIC_ROUNDS = scpc_pkg::CORDIC_ROUNDS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	scpc_sample_if.sink  sample,
	scpc_point_if.source point,
	scpc_cfg_if.sink     cfg
);

	// only the low 16 bits of the range field ever carry data
	localparam int RW   = (RANGE_BITS < scpc_pkg::FIELD_W) ? RANGE_BITS : scpc_pkg::FIELD_W;
	localparam int ZPAD = 32 - ANGLE_BITS;

	// configuration registers
	logic [scpc_pkg::FIELD_W-1:0] range_min_q, range_max_q, angle_start_q, angle_step_q;
	logic [scpc_pkg::FIELD_W-1:0] offset_x_q, offset_y_q, gate_min_q, gate_max_q;

	// front end
	logic                  accept;
	logic                  busy_q;
	logic [ANGLE_BITS-1:0] beam_q;
	logic [ANGLE_BITS-1:0] angle;
	logic [31:0]           turn;       // angle scaled to 2^32 per turn
	logic                  flip;
	logic [31:0]           turn_fold;  // folded into [-1/4, 1/4) turn
	logic [RW-1:0]         range_v;
	logic                  win_ok;
	logic [RW-1:0]         range_q;
	logic                  flip_q, win_ok_q;

	// cell chain and back end
	scpc_pkg::cell_data_t     chain [CORDIC_ROUNDS+1];
	logic [CORDIC_ROUNDS-1:0] cell_vld;
	scpc_pkg::post_in_t       post_in;
	scpc_pkg::point_t         post_res;
	logic                     take;

	// output register
	logic                         out_vld_q, out_kept_q;
	logic [scpc_pkg::POINT_W-1:0] out_x_q, out_y_q;

	// ---------------- configuration port ----------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_min_q   <= '0;
			range_max_q   <= scpc_pkg::SENSOR_RANGE_MAX_RST;
			angle_start_q <= '0;
			angle_step_q  <= '0;
			offset_x_q    <= '0;
			offset_y_q    <= '0;
			gate_min_q    <= '0;
			gate_max_q    <= scpc_pkg::GATE_MAX_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				scpc_pkg::REG_SENSOR_RANGE_MIN: range_min_q   <= cfg.data;
				scpc_pkg::REG_SENSOR_RANGE_MAX: range_max_q   <= cfg.data;
				scpc_pkg::REG_ANGLE_START:      angle_start_q <= cfg.data;
				scpc_pkg::REG_ANGLE_STEP:       angle_step_q  <= cfg.data;
				scpc_pkg::REG_MOUNT_OFFSET_X:   offset_x_q    <= cfg.data;
				scpc_pkg::REG_MOUNT_OFFSET_Y:   offset_y_q    <= cfg.data;
				scpc_pkg::REG_GATE_MIN:         gate_min_q    <= cfg.data;
				scpc_pkg::REG_GATE_MAX:         gate_max_q    <= cfg.data;
				default: ;  // unknown index: write dropped
			endcase
		end
	end

	// ---------------- sample intake ----------------
	// One sample at a time; the output register lets the next one in while
	// a finished point still waits downstream.
	assign sample.ready = !busy_q;
	assign accept       = sample.valid && sample.ready;

	always_comb begin
		angle     = sample.scan_start ? ANGLE_BITS'(angle_start_q) : beam_q;
		turn      = {angle, {ZPAD{1'b0}}};
		// second and third quadrants: take off a half turn, negate at the end
		flip      = turn[31] ^ turn[30];
		turn_fold = flip ? (turn ^ 32'h8000_0000) : turn;
		range_v   = RW'(sample.range_sample);
		win_ok    = !sample.sample_invalid
			&& (scpc_pkg::FIELD_W'(range_v) >= range_min_q)
			&& (scpc_pkg::FIELD_W'(range_v) <= range_max_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			beam_q <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (take) begin
				busy_q <= 1'b0;
			end
			// angle steps after every sample, dropped or not
			if (accept) begin
				beam_q <= angle + ANGLE_BITS'($signed(angle_step_q));
			end
		end
	end

	// per-sample context, stable while the sample is in flight
	always_ff @(posedge clk) begin
		if (accept) begin
			range_q  <= range_v;
			flip_q   <= flip;
			win_ok_q <= win_ok;
		end
	end

	// ---------------- rotation cell chain ----------------
	// The first cell registers round 0 at the accepting edge.
	assign chain[0] = '{
		vld: accept,
		x:   scpc_pkg::CORDIC_K,
		y:   '0,
		z:   scpc_pkg::ZW'($signed(turn_fold))
	};

	for (genvar g = 0; g < CORDIC_ROUNDS; g++) begin : g_cell
		scpc_cell #(
			.ROUND (g)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.d_in   (chain[g]),
			.d_out  (chain[g+1])
		);
		assign cell_vld[g] = chain[g+1].vld;
	end

	// ---------------- scaling and gate ----------------
	assign post_in = '{
		vld:    chain[CORDIC_ROUNDS].vld,
		flip:   flip_q,
		win_ok: win_ok_q,
		x:      chain[CORDIC_ROUNDS].x,
		y:      chain[CORDIC_ROUNDS].y
	};

	scpc_post #(
		.RANGE_W (RW)
	) u_post (
		.clk            (clk),
		.arst_n         (arst_n),
		.p_in           (post_in),
		.range_val      (range_q),
		.mount_offset_x (offset_x_q),
		.mount_offset_y (offset_y_q),
		.gate_min       (gate_min_q),
		.gate_max       (gate_max_q),
		.take           (take),
		.res            (post_res)
	);

	// ---------------- output register ----------------
	assign take = post_res.vld && (!out_vld_q || point.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (take) begin
			out_vld_q <= 1'b1;
		end else if (point.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_x_q    <= post_res.x;
			out_y_q    <= post_res.y;
			out_kept_q <= post_res.kept;
		end
	end

	assign point.valid      = out_vld_q;
	assign point.point_x    = out_x_q;
	assign point.point_y    = out_y_q;
	assign point.point_kept = out_kept_q;

	// ---------------- assertions ----------------
	// never more than one sample in the cell chain
	a_chain_single: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cell_vld))
		else $error("more than one sample in the rotation chain");

	// a finished point only exists for a sample still counted as in flight
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		post_res.vld |-> busy_q)
		else $error("gate result without a sample in flight");

	// a point that is not kept is reported at the origin
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(point.valid && !point.point_kept) |-> (point.point_x == '0 && point.point_y == '0))
		else $error("dropped point carries nonzero coordinates");

endmodule

/* sv/scpc_cell.sv */
// One CORDIC rotation round, registered; cells are chained one per round.
// Depends on scpc_pkg (cell_data_t, atan_turn).
module scpc_cell #(
	parameter int ROUND = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  scpc_pkg::cell_data_t d_in,
	output scpc_pkg::cell_data_t d_out
);

	localparam logic [scpc_pkg::ZW-1:0] ATAN = scpc_pkg::ZW'(scpc_pkg::atan_turn(ROUND));

	logic signed [scpc_pkg::CW-1:0] x_in, y_in, xs, ys, x_nx, y_nx;
	logic signed [scpc_pkg::ZW-1:0] z_in, z_nx;
	logic                           vld_q;
	logic [scpc_pkg::CW-1:0]        x_q, y_q;
	logic [scpc_pkg::ZW-1:0]        z_q;

	always_comb begin
		x_in = $signed(d_in.x);
		y_in = $signed(d_in.y);
		z_in = $signed(d_in.z);
		xs   = x_in >>> ROUND;
		ys   = y_in >>> ROUND;
		if (!z_in[scpc_pkg::ZW-1]) begin
			x_nx = x_in - ys;
			y_nx = y_in + xs;
			z_nx = z_in - $signed(ATAN);
		end else begin
			x_nx = x_in + ys;
			y_nx = y_in - xs;
			z_nx = z_in + $signed(ATAN);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= d_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		x_q <= x_nx;
		y_q <= y_nx;
		z_q <= z_nx;
	end

	assign d_out = '{vld: vld_q, x: x_q, y: y_q, z: z_q};

endmodule

/* sv/scpc_post.sv */
// Flip, scaling by range, rounding, saturation, mount offset and squared-distance obstacle gate.
// Depends on scpc_pkg (post_in_t, point_t, widths).
module scpc_post #(
	parameter int RANGE_W = scpc_pkg::RANGE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  scpc_pkg::post_in_t            p_in,
	input  logic [RANGE_W-1:0]            range_val,
	input  logic [scpc_pkg::FIELD_W-1:0]  mount_offset_x,
	input  logic [scpc_pkg::FIELD_W-1:0]  mount_offset_y,
	input  logic [scpc_pkg::FIELD_W-1:0]  gate_min,
	input  logic [scpc_pkg::FIELD_W-1:0]  gate_max,
	input  logic                          take,
	output scpc_pkg::point_t              res
);

	localparam int PROD_W = RANGE_W + 1 + scpc_pkg::CW;
	localparam int RND_W  = PROD_W + 1;
	localparam int PW     = scpc_pkg::POINT_W;
	localparam int BW     = PW + 1;
	localparam int SQ_W   = 2 * BW;
	localparam int D2_W   = SQ_W + 1;
	localparam int GSQ_W  = 2 * scpc_pkg::FIELD_W;

	function automatic logic [PW-1:0] sat_point(input logic signed [RND_W-1:0] v);
		logic [PW-1:0] r;
		if (v > RND_W'(65535)) begin
			r = 17'h0FFFF;
		end else if (v < -RND_W'(65535)) begin
			r = 17'h10001;
		end else begin
			r = PW'(v);
		end
		return r;
	endfunction

	// s1: flip and multiply
	logic signed [scpc_pkg::CW-1:0] cx, cy;
	logic signed [PROD_W-1:0]       prod_x, prod_y;
	logic signed [PROD_W-1:0]       prod_x_s1, prod_y_s1;
	logic                           vld_s1, win_s1;
	// s2: round and saturate
	logic signed [RND_W-1:0]        rnd_x, rnd_y;
	logic [PW-1:0]                  px_s2, py_s2;
	logic                           vld_s2, win_s2;
	// s3: offset and square
	logic signed [BW-1:0]           bx, by;
	logic signed [SQ_W-1:0]         bx2_s3, by2_s3;
	logic [PW-1:0]                  px_s3, py_s3;
	logic                           vld_s3, win_s3;
	// s4: compare
	logic [D2_W-1:0]                d2;
	logic                           kept;
	logic [GSQ_W-1:0]               gmin_sq_q, gmax_sq_q;
	logic                           vld_s4, kept_s4;
	logic [PW-1:0]                  px_s4, py_s4;

	always_comb begin
		cx     = p_in.flip ? -$signed(p_in.x) : $signed(p_in.x);
		cy     = p_in.flip ? -$signed(p_in.y) : $signed(p_in.y);
		prod_x = PROD_W'($signed({1'b0, range_val})) * PROD_W'(cx);
		prod_y = PROD_W'($signed({1'b0, range_val})) * PROD_W'(cy);
		rnd_x  = (RND_W'(prod_x_s1) + (RND_W'(1) <<< (scpc_pkg::FRAC - 1)))
			>>> scpc_pkg::FRAC;
		rnd_y  = (RND_W'(prod_y_s1) + (RND_W'(1) <<< (scpc_pkg::FRAC - 1)))
			>>> scpc_pkg::FRAC;
		bx     = $signed({px_s2[PW-1], px_s2}) + $signed(BW'($signed(mount_offset_x)));
		by     = $signed({py_s2[PW-1], py_s2}) + $signed(BW'($signed(mount_offset_y)));
		d2     = {1'b0, bx2_s3} + {1'b0, by2_s3};
		kept   = win_s3 && (d2 >= D2_W'(gmin_sq_q)) && (d2 <= D2_W'(gmax_sq_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= p_in.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			if (vld_s3) begin
				vld_s4 <= 1'b1;
			end else if (take) begin
				vld_s4 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		gmin_sq_q <= GSQ_W'(gate_min) * GSQ_W'(gate_min);
		gmax_sq_q <= GSQ_W'(gate_max) * GSQ_W'(gate_max);
		prod_x_s1 <= prod_x;
		prod_y_s1 <= prod_y;
		win_s1    <= p_in.win_ok;
		px_s2     <= sat_point(rnd_x);
		py_s2     <= sat_point(rnd_y);
		win_s2    <= win_s1;
		bx2_s3    <= SQ_W'(bx) * SQ_W'(bx);
		by2_s3    <= SQ_W'(by) * SQ_W'(by);
		px_s3     <= px_s2;
		py_s3     <= py_s2;
		win_s3    <= win_s2;
		// last stage holds while the output register is full
		if (vld_s3) begin
			kept_s4 <= kept;
			px_s4   <= kept ? px_s3 : '0;
			py_s4   <= kept ? py_s3 : '0;
		end
	end

	assign res = '{vld: vld_s4, kept: kept_s4, x: px_s4, y: py_s4};

endmodule
